// ----- rtl/cpcr_pkg.sv -----
// Shared constants, types and helpers for the circle pair collision response block.
package cpcr_pkg;

    // Field formats.
    localparam int FRAC_BITS = 8;
    localparam int FW        = 20;
    localparam int RADW      = 10;

    // Centre difference and squared distance.
    localparam int DW   = FW + 1;
    localparam int D2W  = 2 * DW;
    localparam int RSW  = RADW + 1;
    localparam int LIMW = 2 * RSW + 2 * FRAC_BITS;
    localparam int CMPW = (D2W > LIMW) ? D2W : LIMW;
    localparam int SW   = LIMW;

    // Reciprocal root: quotient of 2^(32+2F) by S, then its integer root.
    localparam int TW  = 33 + 2 * FRAC_BITS;
    localparam int QB  = TW;
    localparam int NSQ = (TW + 1) / 2;
    localparam int RW  = 17 + FRAC_BITS;
    localparam int LAT = QB + NSQ;

    // Unit vector, dot products and projections.
    localparam int UW      = 18;
    localparam int PW      = DW + RW + 1;
    localparam int TPW     = FW + UW;
    localparam int DOTW    = FW + UW + 1;
    localparam int LOW     = DOTW / 2;
    localparam int HIW     = DOTW - LOW;
    localparam int PHW     = HIW + UW;
    localparam int PLOW    = LOW + 1 + UW;
    localparam int PRW     = DOTW + UW;
    localparam int PJW     = PRW - 31;
    localparam int VW      = PJW + 2;
    localparam int SH_EXCH = 32;
    localparam int SH_REFL = 31;

    // Placement in Q.(F+18).
    localparam int RQW      = RADW + 3;
    localparam int PMW      = RQW + 1 + UW;
    localparam int PLACE_SH = 18;
    localparam int OFFW     = PMW + FRAC_BITS;
    localparam int BASEW    = DW + PLACE_SH;
    localparam int PLW      = ((OFFW > BASEW) ? OFFW : BASEW) + 1;
    localparam int POW      = PLW - PLACE_SH;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int SATW = 64;

    // How a contact is resolved.
    typedef enum logic [1:0] {
        MODE_EXCH,
        MODE_MOVE_A,
        MODE_MOVE_B
    } t_mode;

    // One classified transaction as it travels from the front to the back.
    typedef struct packed {
        logic signed [FW-1:0] a_pos_x;
        logic signed [FW-1:0] a_pos_y;
        logic signed [FW-1:0] b_pos_x;
        logic signed [FW-1:0] b_pos_y;
        logic signed [FW-1:0] a_vel_x;
        logic signed [FW-1:0] a_vel_y;
        logic signed [FW-1:0] b_vel_x;
        logic signed [FW-1:0] b_vel_y;
        logic [RADW-1:0]      a_radius;
        logic [RADW-1:0]      b_radius;
        logic                 hit;
        t_mode                mode;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [SW-1:0]        s;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic                 hit;
        logic signed [FW-1:0] new_a_pos_x;
        logic signed [FW-1:0] new_a_pos_y;
        logic signed [FW-1:0] new_b_pos_x;
        logic signed [FW-1:0] new_b_pos_y;
        logic signed [FW-1:0] new_a_vel_x;
        logic signed [FW-1:0] new_a_vel_y;
        logic signed [FW-1:0] new_b_vel_x;
        logic signed [FW-1:0] new_b_vel_y;
    } t_result;

    // Queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Clamp a wide signed value to the field range.
    function automatic logic signed [FW-1:0] sat(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi;
        logic signed [SATW-1:0] lo;
        hi = SATW'((64'sd1 <<< (FW - 1)) - 64'sd1);
        lo = -SATW'(64'sd1 <<< (FW - 1));
        if (v > hi) begin
            sat = FW'(hi);
        end else if (v < lo) begin
            sat = FW'(lo);
        end else begin
            sat = FW'(v);
        end
    endfunction

endpackage

// ----- rtl/cpcr_front.sv -----
// Front part: takes transactions, measures the centre distance and classifies the contact.
module cpcr_front
    import cpcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_push,
    input  logic signed [FW-1:0] i_a_pos_x,
    input  logic signed [FW-1:0] i_a_pos_y,
    input  logic signed [FW-1:0] i_b_pos_x,
    input  logic signed [FW-1:0] i_b_pos_y,
    input  logic signed [FW-1:0] i_a_vel_x,
    input  logic signed [FW-1:0] i_a_vel_y,
    input  logic signed [FW-1:0] i_b_vel_x,
    input  logic signed [FW-1:0] i_b_vel_y,
    input  logic [RADW-1:0]      i_a_radius,
    input  logic [RADW-1:0]      i_b_radius,
    input  logic                 i_a_dynamic,
    input  logic                 i_b_dynamic,
    output logic                 o_valid,
    output t_item                o_item
);

    logic                    r_v1, r_v2, r_v3;
    t_item                   n_i1, r_i1, r_i2, n_i3, r_i3;
    logic                    r_adyn1, r_bdyn1, r_adyn2, r_bdyn2;
    logic [RSW-1:0]          r_rs1;
    logic signed [D2W-1:0]   sq_x, sq_y;
    logic [D2W-1:0]          n_d2, r_d2;
    logic [2*RSW-1:0]        r_lim2;
    logic                    n_hit;

    // Valid bits move with the shared enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage one: capture the fields and form the centre difference.
    always_comb begin
        n_i1          = '0;
        n_i1.a_pos_x  = i_a_pos_x;
        n_i1.a_pos_y  = i_a_pos_y;
        n_i1.b_pos_x  = i_b_pos_x;
        n_i1.b_pos_y  = i_b_pos_y;
        n_i1.a_vel_x  = i_a_vel_x;
        n_i1.a_vel_y  = i_a_vel_y;
        n_i1.b_vel_x  = i_b_vel_x;
        n_i1.b_vel_y  = i_b_vel_y;
        n_i1.a_radius = i_a_radius;
        n_i1.b_radius = i_b_radius;
        n_i1.dx       = DW'(i_a_pos_x) - DW'(i_b_pos_x);
        n_i1.dy       = DW'(i_a_pos_y) - DW'(i_b_pos_y);
    end

    // Stage two: squared distance and squared radius sum.
    assign sq_x = r_i1.dx * r_i1.dx;
    assign sq_y = r_i1.dy * r_i1.dy;
    assign n_d2 = $unsigned(sq_x) + $unsigned(sq_y);

    // Stage three: contact test and choice of resolution.
    always_comb begin
        n_hit  = CMPW'(r_d2) <= CMPW'({r_lim2, {(2 * FRAC_BITS){1'b0}}});
        n_i3   = r_i2;
        n_i3.hit = n_hit;
        n_i3.s = SW'(r_d2);
        if (r_adyn2 && r_bdyn2) begin
            n_i3.mode = MODE_EXCH;
        end else if (!r_bdyn2) begin
            n_i3.mode = MODE_MOVE_A;
        end else begin
            n_i3.mode = MODE_MOVE_B;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i1    <= n_i1;
            r_adyn1 <= i_a_dynamic;
            r_bdyn1 <= i_b_dynamic;
            r_rs1   <= RSW'(i_a_radius) + RSW'(i_b_radius);
            r_i2    <= r_i1;
            r_adyn2 <= r_adyn1;
            r_bdyn2 <= r_bdyn1;
            r_d2    <= n_d2;
            r_lim2  <= r_rs1 * r_rs1;
            r_i3    <= n_i3;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_i3;

endmodule

// ----- rtl/cpcr_queue.sv -----
// Short queue that decouples the front part from the back part.
module cpcr_queue
    import cpcr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

// ----- rtl/cpcr_rsqrt.sv -----
// Pipelined reciprocal square root: a restoring divider followed by a digit-by-digit root.
module cpcr_rsqrt
    import cpcr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_s,
    output logic [RW-1:0] o_r
);

    logic [SW-1:0] r_rem [QB];
    logic [SW-1:0] r_div [QB];
    logic [TW-1:0] r_q   [QB];
    logic [TW-1:0] r_x   [NSQ];
    logic [TW-1:0] r_res [NSQ];

    // Divider: one quotient bit of 2^(TW-1) / S per stage, top bit first.
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [SW:0]   rem_sh;
        logic [SW-1:0] dvs;
        logic [TW-1:0] q_in;
        logic          ge;
        if (k == 0) begin : g_first
            assign rem_sh = (SW+1)'(1);
            assign dvs    = i_s;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_sh = {r_rem[k-1], 1'b0};
            assign dvs    = r_div[k-1];
            assign q_in   = r_q[k-1];
        end
        assign ge = rem_sh >= {1'b0, dvs};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? SW'(rem_sh - {1'b0, dvs}) : SW'(rem_sh);
                r_div[k] <= dvs;
                r_q[k]   <= {q_in[TW-2:0], ge};
            end
        end
    end

    // Integer root: one result bit per stage.
    for (genvar k = 0; k < NSQ; k++) begin : g_root
        localparam logic [TW:0] BITV = (TW+1)'(1) << (2 * (NSQ - 1 - k));
        logic [TW-1:0] x_in;
        logic [TW-1:0] res_in;
        logic [TW:0]   sum;
        logic          ge;
        if (k == 0) begin : g_first
            assign x_in   = r_q[QB-1];
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
        end
        assign sum = {1'b0, res_in} + BITV;
        assign ge  = {1'b0, x_in} >= sum;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= ge ? TW'({1'b0, x_in} - sum) : x_in;
                r_res[k] <= ge ? (res_in >> 1) + TW'(BITV) : (res_in >> 1);
            end
        end
    end

    assign o_r = r_res[NSQ-1][RW-1:0];

endmodule

// ----- rtl/cpcr_back.sv -----
// Back part: normalizes the centre line, then exchanges or reflects velocities and places circles.
module cpcr_back
    import cpcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qstat  i_qstat,
    input  t_item   i_item,
    output logic    o_qpop,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_res
);

    logic                    en;
    logic                    r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    t_item                   r_i0, r_i1, r_i2, r_i3, r_i4, r_i5, r_i6;
    logic                    r_dv [LAT];
    t_item                   r_di [LAT];
    logic [RW-1:0]           w_r;

    logic signed [PW-1:0]    r_px, r_py, neg_px, neg_py;
    logic signed [UW-1:0]    r_abx, r_aby, r_bax, r_bay;
    logic signed [UW-1:0]    u2x, u2y;
    logic signed [UW-1:0]    r_bax3, r_bay3, r_u2x3, r_u2y3;
    logic signed [UW-1:0]    r_bax4, r_bay4, r_u2x4, r_u2y4;
    logic                    exch2, exch3, exch5, exch6;
    logic [RQW-1:0]          rq_a, rq_b;
    logic [RSW-1:0]          rsum;
    logic signed [TPW-1:0]   r_ta_x, r_ta_y, r_tb_x, r_tb_y;
    logic signed [PMW-1:0]   r_ma_x, r_ma_y, r_mb_x, r_mb_y;
    logic signed [DOTW-1:0]  r_da, r_db;
    logic signed [DW-1:0]    mid_x, mid_y;
    logic signed [PLW-1:0]   base_ax, base_ay, base_bx, base_by;
    logic signed [PLW-1:0]   sum_ax, sum_ay, sum_bx, sum_by;
    logic signed [POW-1:0]   r_npa_x4, r_npa_y4, r_npb_x4, r_npb_y4;
    logic signed [POW-1:0]   r_npa_x5, r_npa_y5, r_npb_x5, r_npb_y5;
    logic signed [POW-1:0]   r_npa_x6, r_npa_y6, r_npb_x6, r_npb_y6;
    logic signed [PHW-1:0]   r_hpa_x, r_hpa_y, r_hpb_x, r_hpb_y;
    logic signed [PLOW-1:0]  r_lpa_x, r_lpa_y, r_lpb_x, r_lpb_y;
    logic signed [PRW-1:0]   f_pa_x, f_pa_y, f_pb_x, f_pb_y;
    logic signed [PJW-1:0]   r_pa_x, r_pa_y, r_pb_x, r_pb_y;
    logic signed [VW-1:0]    va_x, va_y, vb_x, vb_y;
    logic signed [POW-1:0]   pa_x, pa_y, pb_x, pb_y;
    t_result                 n_res, r_res;

    // The whole back pipeline advances unless a finished result is waiting and is not popped.
    assign en     = !r_v7 || i_pop;
    assign o_qpop = en && !i_qstat.empty;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= !i_qstat.empty;
            r_dv[0] <= r_v0;
            for (int k = 1; k < LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_v1 <= r_dv[LAT-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Reciprocal root of the squared distance, with the transaction delayed alongside.
    cpcr_rsqrt u_rsqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s   (r_i0.s),
        .o_r   (w_r)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i0    <= i_item;
            r_di[0] <= r_i0;
            for (int k = 1; k < LAT; k++) begin
                r_di[k] <= r_di[k-1];
            end
        end
    end

    // Unit vectors in both directions, and the operands chosen by the mode.
    assign neg_px = -r_px;
    assign neg_py = -r_py;
    assign exch2  = r_i2.mode == MODE_EXCH;
    assign u2x    = (r_i2.mode == MODE_MOVE_B) ? r_abx : r_bax;
    assign u2y    = (r_i2.mode == MODE_MOVE_B) ? r_aby : r_bay;
    assign rsum   = RSW'(r_i2.a_radius) + RSW'(r_i2.b_radius);
    assign rq_a   = exch2 ? RQW'({r_i2.a_radius, 2'b01}) : RQW'({rsum, 2'b01});
    assign rq_b   = exch2 ? RQW'({r_i2.b_radius, 2'b01}) : RQW'({rsum, 2'b01});

    // Placement sums: centre (midpoint or other circle) plus the offset along the normal.
    assign exch3   = r_i3.mode == MODE_EXCH;
    assign mid_x   = DW'(r_i3.a_pos_x) + DW'(r_i3.b_pos_x);
    assign mid_y   = DW'(r_i3.a_pos_y) + DW'(r_i3.b_pos_y);
    assign base_ax = exch3 ? (PLW'(mid_x) <<< (PLACE_SH - 1))
                           : (PLW'(r_i3.b_pos_x) <<< PLACE_SH);
    assign base_ay = exch3 ? (PLW'(mid_y) <<< (PLACE_SH - 1))
                           : (PLW'(r_i3.b_pos_y) <<< PLACE_SH);
    assign base_bx = exch3 ? (PLW'(mid_x) <<< (PLACE_SH - 1))
                           : (PLW'(r_i3.a_pos_x) <<< PLACE_SH);
    assign base_by = exch3 ? (PLW'(mid_y) <<< (PLACE_SH - 1))
                           : (PLW'(r_i3.a_pos_y) <<< PLACE_SH);
    assign sum_ax  = base_ax + (PLW'(r_ma_x) <<< FRAC_BITS);
    assign sum_ay  = base_ay + (PLW'(r_ma_y) <<< FRAC_BITS);
    assign sum_bx  = base_bx + (PLW'(r_mb_x) <<< FRAC_BITS);
    assign sum_by  = base_by + (PLW'(r_mb_y) <<< FRAC_BITS);

    // Projections: recombine the partial products and scale by one or two.
    assign exch5  = r_i5.mode == MODE_EXCH;
    assign f_pa_x = (PRW'(r_hpa_x) <<< LOW) + PRW'(r_lpa_x);
    assign f_pa_y = (PRW'(r_hpa_y) <<< LOW) + PRW'(r_lpa_y);
    assign f_pb_x = (PRW'(r_hpb_x) <<< LOW) + PRW'(r_lpb_x);
    assign f_pb_y = (PRW'(r_hpb_y) <<< LOW) + PRW'(r_lpb_y);

    // Arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // Scale the difference by the reciprocal length.
            r_i1 <= r_di[LAT-1];
            r_px <= r_di[LAT-1].dx * $signed({1'b0, w_r});
            r_py <= r_di[LAT-1].dy * $signed({1'b0, w_r});
            // Floor to Q.16 for both directions.
            r_i2  <= r_i1;
            r_abx <= UW'(r_px >>> FRAC_BITS);
            r_aby <= UW'(r_py >>> FRAC_BITS);
            r_bax <= UW'(neg_px >>> FRAC_BITS);
            r_bay <= UW'(neg_py >>> FRAC_BITS);
            // Dot terms and placement offsets.
            r_i3   <= r_i2;
            r_ta_x <= r_i2.a_vel_x * r_bax;
            r_ta_y <= r_i2.a_vel_y * r_bay;
            r_tb_x <= r_i2.b_vel_x * u2x;
            r_tb_y <= r_i2.b_vel_y * u2y;
            r_ma_x <= $signed({1'b0, rq_a}) * r_abx;
            r_ma_y <= $signed({1'b0, rq_a}) * r_aby;
            r_mb_x <= $signed({1'b0, rq_b}) * r_bax;
            r_mb_y <= $signed({1'b0, rq_b}) * r_bay;
            r_bax3 <= r_bax;
            r_bay3 <= r_bay;
            r_u2x3 <= u2x;
            r_u2y3 <= u2y;
            // Dot sums and floored placements.
            r_i4     <= r_i3;
            r_da     <= DOTW'(r_ta_x) + DOTW'(r_ta_y);
            r_db     <= DOTW'(r_tb_x) + DOTW'(r_tb_y);
            r_npa_x4 <= POW'(sum_ax >>> PLACE_SH);
            r_npa_y4 <= POW'(sum_ay >>> PLACE_SH);
            r_npb_x4 <= POW'(sum_bx >>> PLACE_SH);
            r_npb_y4 <= POW'(sum_by >>> PLACE_SH);
            r_bax4   <= r_bax3;
            r_bay4   <= r_bay3;
            r_u2x4   <= r_u2x3;
            r_u2y4   <= r_u2y3;
            // Projection partial products on the high and low halves of each dot.
            r_i5     <= r_i4;
            r_hpa_x  <= $signed(r_da[DOTW-1:LOW]) * r_bax4;
            r_hpa_y  <= $signed(r_da[DOTW-1:LOW]) * r_bay4;
            r_hpb_x  <= $signed(r_db[DOTW-1:LOW]) * r_u2x4;
            r_hpb_y  <= $signed(r_db[DOTW-1:LOW]) * r_u2y4;
            r_lpa_x  <= $signed({1'b0, r_da[LOW-1:0]}) * r_bax4;
            r_lpa_y  <= $signed({1'b0, r_da[LOW-1:0]}) * r_bay4;
            r_lpb_x  <= $signed({1'b0, r_db[LOW-1:0]}) * r_u2x4;
            r_lpb_y  <= $signed({1'b0, r_db[LOW-1:0]}) * r_u2y4;
            r_npa_x5 <= r_npa_x4;
            r_npa_y5 <= r_npa_y4;
            r_npb_x5 <= r_npb_x4;
            r_npb_y5 <= r_npb_y4;
            // Projected components.
            r_i6     <= r_i5;
            r_pa_x   <= exch5 ? PJW'(f_pa_x >>> SH_EXCH) : PJW'(f_pa_x >>> SH_REFL);
            r_pa_y   <= exch5 ? PJW'(f_pa_y >>> SH_EXCH) : PJW'(f_pa_y >>> SH_REFL);
            r_pb_x   <= exch5 ? PJW'(f_pb_x >>> SH_EXCH) : PJW'(f_pb_x >>> SH_REFL);
            r_pb_y   <= exch5 ? PJW'(f_pb_y >>> SH_EXCH) : PJW'(f_pb_y >>> SH_REFL);
            r_npa_x6 <= r_npa_x5;
            r_npa_y6 <= r_npa_y5;
            r_npb_x6 <= r_npb_x5;
            r_npb_y6 <= r_npb_y5;
            // Final result.
            r_res <= n_res;
        end
    end

    // Velocity update and result selection.
    assign exch6 = r_i6.mode == MODE_EXCH;
    always_comb begin
        va_x = VW'(r_i6.a_vel_x);
        va_y = VW'(r_i6.a_vel_y);
        vb_x = VW'(r_i6.b_vel_x);
        vb_y = VW'(r_i6.b_vel_y);
        pa_x = POW'(r_i6.a_pos_x);
        pa_y = POW'(r_i6.a_pos_y);
        pb_x = POW'(r_i6.b_pos_x);
        pb_y = POW'(r_i6.b_pos_y);
        if (r_i6.hit) begin
            case (r_i6.mode)
                MODE_EXCH: begin
                    va_x = VW'(r_i6.a_vel_x) - VW'(r_pa_x) + VW'(r_pb_x);
                    va_y = VW'(r_i6.a_vel_y) - VW'(r_pa_y) + VW'(r_pb_y);
                    vb_x = VW'(r_i6.b_vel_x) - VW'(r_pb_x) + VW'(r_pa_x);
                    vb_y = VW'(r_i6.b_vel_y) - VW'(r_pb_y) + VW'(r_pa_y);
                    pa_x = r_npa_x6;
                    pa_y = r_npa_y6;
                    pb_x = r_npb_x6;
                    pb_y = r_npb_y6;
                end
                MODE_MOVE_A: begin
                    va_x = VW'(r_i6.a_vel_x) - VW'(r_pa_x);
                    va_y = VW'(r_i6.a_vel_y) - VW'(r_pa_y);
                    pa_x = r_npa_x6;
                    pa_y = r_npa_y6;
                end
                MODE_MOVE_B: begin
                    vb_x = VW'(r_i6.b_vel_x) - VW'(r_pb_x);
                    vb_y = VW'(r_i6.b_vel_y) - VW'(r_pb_y);
                    pb_x = r_npb_x6;
                    pb_y = r_npb_y6;
                end
                default: begin
                    va_x = VW'(r_i6.a_vel_x);
                end
            endcase
        end
        n_res.hit         = r_i6.hit;
        n_res.new_a_pos_x = sat(SATW'(pa_x));
        n_res.new_a_pos_y = sat(SATW'(pa_y));
        n_res.new_b_pos_x = sat(SATW'(pb_x));
        n_res.new_b_pos_y = sat(SATW'(pb_y));
        n_res.new_a_vel_x = sat(SATW'(va_x));
        n_res.new_a_vel_y = sat(SATW'(va_y));
        n_res.new_b_vel_x = sat(SATW'(vb_x));
        n_res.new_b_vel_y = sat(SATW'(vb_y));
        if (exch6 && !r_i6.hit) begin
            n_res.hit = 1'b0;
        end
    end

    assign o_valid = r_v7;
    assign o_res   = r_res;

endmodule

// ----- rtl/circle_pair_collision_response.sv -----
// Top level of the circle pair collision response block.
// Resolves one pair of circles per transaction and returns one result for each.
// A new transaction can be taken every clock cycle while full is low, and most of the
// pipeline that lies between a transaction and its result is in the reciprocal
// square root unit (a 49-stage divider followed by a 25-stage root). The front part
// classifies the contact in three stages and hands transactions to a four-entry queue;
// the back part stalls as a whole while its finished result is not popped, and the
// front keeps taking transactions until that queue fills. Positions and velocities are
// signed Q12.8; each result field is saturated to its 20-bit range.
module circle_pair_collision_response
    import cpcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [FW-1:0] i_a_pos_x,
    input  logic signed [FW-1:0] i_a_pos_y,
    input  logic signed [FW-1:0] i_b_pos_x,
    input  logic signed [FW-1:0] i_b_pos_y,
    input  logic signed [FW-1:0] i_a_vel_x,
    input  logic signed [FW-1:0] i_a_vel_y,
    input  logic signed [FW-1:0] i_b_vel_x,
    input  logic signed [FW-1:0] i_b_vel_y,
    input  logic [RADW-1:0]      i_a_radius,
    input  logic [RADW-1:0]      i_b_radius,
    input  logic                 i_a_dynamic,
    input  logic                 i_b_dynamic,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_hit,
    output logic signed [FW-1:0] o_new_a_pos_x,
    output logic signed [FW-1:0] o_new_a_pos_y,
    output logic signed [FW-1:0] o_new_b_pos_x,
    output logic signed [FW-1:0] o_new_b_pos_y,
    output logic signed [FW-1:0] o_new_a_vel_x,
    output logic signed [FW-1:0] o_new_a_vel_y,
    output logic signed [FW-1:0] o_new_b_vel_x,
    output logic signed [FW-1:0] o_new_b_vel_y
);

    logic    f_en, f_valid, q_push, q_pop, b_valid;
    t_item   f_item, q_item;
    t_qstat  q_stat;
    t_result b_res;

    // Front advances unless its last stage holds a transaction the queue cannot take.
    assign f_en   = !f_valid || !q_stat.full;
    assign q_push = f_valid && !q_stat.full;
    assign full   = !f_en;

    cpcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (f_en),
        .i_push      (push),
        .i_a_pos_x   (i_a_pos_x),
        .i_a_pos_y   (i_a_pos_y),
        .i_b_pos_x   (i_b_pos_x),
        .i_b_pos_y   (i_b_pos_y),
        .i_a_vel_x   (i_a_vel_x),
        .i_a_vel_y   (i_a_vel_y),
        .i_b_vel_x   (i_b_vel_x),
        .i_b_vel_y   (i_b_vel_y),
        .i_a_radius  (i_a_radius),
        .i_b_radius  (i_b_radius),
        .i_a_dynamic (i_a_dynamic),
        .i_b_dynamic (i_b_dynamic),
        .o_valid     (f_valid),
        .o_item      (f_item)
    );

    cpcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    cpcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (q_stat),
        .i_item  (q_item),
        .o_qpop  (q_pop),
        .i_pop   (pop),
        .o_valid (b_valid),
        .o_res   (b_res)
    );

    // Result ports.
    assign empty         = !b_valid;
    assign o_hit         = b_res.hit;
    assign o_new_a_pos_x = b_res.new_a_pos_x;
    assign o_new_a_pos_y = b_res.new_a_pos_y;
    assign o_new_b_pos_x = b_res.new_b_pos_x;
    assign o_new_b_pos_y = b_res.new_b_pos_y;
    assign o_new_a_vel_x = b_res.new_a_vel_x;
    assign o_new_a_vel_y = b_res.new_a_vel_y;
    assign o_new_b_vel_x = b_res.new_b_vel_x;
    assign o_new_b_vel_y = b_res.new_b_vel_y;

`ifndef SYNTHESIS
    // The front never writes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // A waiting result that is not popped holds the back part, so the queue is not read.
    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |-> !q_pop)
        else $error("queue read while the back part is stalled");

    // The queue is never reported full and empty together.
    a_qstat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");
`endif

endmodule
